@@ sv/matrix_stack_vector_transform_macros.svh @@
// Assertion macros for the matrix stack vector transform block.
// Used by files that check their own logic; expects aclk and aresetn in scope.
`ifndef MATRIX_STACK_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX_STACK_VECTOR_TRANSFORM_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MSVT_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("msvt invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define MSVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("msvt sequence violated");

`endif

@@ sv/msvt_pkg.sv @@
// Shared types and constants of the matrix stack vector transform block.
// No dependencies; imported by every module of the block.
`default_nettype none

package msvt_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int STACK_DEPTH_DEF = 20;
    localparam int LEVEL_W         = 5;
    localparam int COEF_W          = 16;
    localparam int ROW_W           = 3 * COEF_W;
    localparam int WORD_W          = 32;

    localparam logic [2:0] CMD_ROTATE     = 3'd0;
    localparam logic [2:0] CMD_ROT_TRANS  = 3'd1;
    localparam logic [2:0] CMD_PUSH       = 3'd2;
    localparam logic [2:0] CMD_POP        = 3'd3;
    localparam logic [2:0] CMD_LOAD_ROW   = 3'd4;
    localparam logic [2:0] CMD_LOAD_TRANS = 3'd5;

    localparam logic [1:0] ROW_COUNT = 2'd3;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic        [1:0]  row_sel;
        logic signed [15:0] coef_a;
        logic signed [15:0] coef_b;
        logic signed [15:0] coef_c;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]        out_x;
        logic signed [31:0]        out_y;
        logic signed [31:0]        out_z;
        logic                      refused;
        logic        [LEVEL_W-1:0] level;
    } out_item_t;

    typedef struct packed {
        logic [2:0][ROW_W-1:0]  rot;
        logic [2:0][WORD_W-1:0] trans;
    } stack_entry_t;

    typedef struct packed {
        logic capture;
        logic add_trans;
    } lane_ctrl_t;

    typedef struct packed {
        logic               load;
        logic               is_xform;
        logic               refused;
        logic [LEVEL_W-1:0] level;
    } res_ctrl_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

@@ sv/msvt_lane.sv @@
// One row lane: three 16x16 products registered, then sum, shift and optional offset.
// Depends on msvt_pkg.
`default_nettype none

module msvt_lane
    import msvt_pkg::*;
(
    input  wire logic                     aclk,
    input  wire lane_ctrl_t               ctrl,
    input  wire logic [ROW_W-1:0]         row,
    input  wire logic [2:0][COEF_W-1:0]   vec,
    input  wire logic [WORD_W-1:0]        trans,
    output logic      [WORD_W-1:0]        res
);

    logic signed [WORD_W-1:0] prod_reg  [3];
    logic signed [WORD_W-1:0] prod_next [3];
    logic        [WORD_W-1:0] sum;
    logic signed [WORD_W-1:0] shifted;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_next[c] = $signed(row[COEF_W*c +: COEF_W]) * $signed(vec[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            for (int c = 0; c < 3; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
    end

    always_comb begin
        sum     = prod_reg[0] + prod_reg[1] + prod_reg[2];
        shifted = $signed(sum) >>> FRAC_BITS;
        res     = ctrl.add_trans ? shifted + trans : shifted;
    end

endmodule

`default_nettype wire

@@ sv/msvt_merge.sv @@
// Merging stage: combines the three lane results with stack status into the
// result register. Depends on msvt_pkg.
`default_nettype none

module msvt_merge
    import msvt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire res_ctrl_t              ctrl,
    input  wire logic [2:0][WORD_W-1:0] lane_res,
    output logic                        free,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_item_t                   m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    out_item_t item_next;

    always_comb begin
        free       = !valid_reg || m_ready;
        valid_next = ctrl.load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
        item_next.out_x   = ctrl.is_xform ? lane_res[0] : '0;
        item_next.out_y   = ctrl.is_xform ? lane_res[1] : '0;
        item_next.out_z   = ctrl.is_xform ? lane_res[2] : '0;
        item_next.refused = ctrl.refused;
        item_next.level   = ctrl.level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

@@ sv/matrix_stack_vector_transform.sv @@
// Steps per item: accept, execute, finish; the next item is taken after finish.
// Execute registers the lane products and, for a pop, reads the save-stack memory
// into a register; finish registers the result once the output register is free.
// The input side accepts again while a result still waits in the output register.
// Reset (aresetn, synchronous, active low) clears the matrix, translation, level
// and handshake state; save-stack memory is not cleared.
`default_nettype none
`include "matrix_stack_vector_transform_macros.svh"

module matrix_stack_vector_transform
    import msvt_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    seq_state_t             state_reg;
    seq_state_t             state_next;
    in_item_t               item_reg;
    logic [2:0][ROW_W-1:0]  rot_reg;
    logic [2:0][ROW_W-1:0]  rot_next;
    logic [2:0][WORD_W-1:0] trans_reg;
    logic [2:0][WORD_W-1:0] trans_next;
    logic [LVL_W-1:0]       level_reg;
    logic [LVL_W-1:0]       level_next;
    logic [LVL_W-1:0]       level_dec;
    logic                   refused_reg;
    logic                   refused_next;
    logic                   pop_pend_reg;
    logic                   pop_pend_next;

    logic                   exec_en;
    logic                   fin_go;
    logic                   res_free;
    logic                   push_we;
    logic                   pop_re;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    stack_entry_t           wr_entry;
    stack_entry_t           rd_reg;
    stack_entry_t           mem [STACK_DEPTH];

    lane_ctrl_t             lane_ctrl;
    res_ctrl_t              res_ctrl;
    logic [2:0][COEF_W-1:0] vec;
    logic [2:0][WORD_W-1:0] lane_res;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:   if (s_valid) state_next = SEQ_EXEC;
            SEQ_EXEC:   state_next = SEQ_FINISH;
            SEQ_FINISH: if (res_free) state_next = SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        exec_en = 1'b0;
        fin_go  = 1'b0;
        unique case (state_reg)
            SEQ_IDLE:   s_ready = 1'b1;
            SEQ_EXEC:   exec_en = 1'b1;
            SEQ_FINISH: fin_go  = res_free;
            default:    s_ready = 1'b0;
        endcase
    end

    always_comb begin
        rot_next      = rot_reg;
        trans_next    = trans_reg;
        level_next    = level_reg;
        refused_next  = refused_reg;
        pop_pend_next = pop_pend_reg;
        push_we       = 1'b0;
        pop_re        = 1'b0;
        level_dec     = level_reg - 1'b1;
        wr_addr       = level_reg[ADDR_W-1:0];
        rd_addr       = level_dec[ADDR_W-1:0];
        wr_entry.rot   = rot_reg;
        wr_entry.trans = trans_reg;
        if (exec_en) begin
            refused_next  = 1'b0;
            pop_pend_next = 1'b0;
            unique case (item_reg.cmd)
                CMD_PUSH: begin
                    if (level_reg >= LVL_W'(STACK_DEPTH)) begin
                        refused_next = 1'b1;
                    end else begin
                        push_we    = 1'b1;
                        level_next = level_reg + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (level_reg == '0) begin
                        refused_next = 1'b1;
                    end else begin
                        pop_re        = 1'b1;
                        pop_pend_next = 1'b1;
                        level_next    = level_dec;
                    end
                end
                CMD_LOAD_ROW: begin
                    if (item_reg.row_sel < ROW_COUNT) begin
                        rot_next[item_reg.row_sel] =
                            {item_reg.coef_c, item_reg.coef_b, item_reg.coef_a};
                    end
                end
                CMD_LOAD_TRANS: begin
                    trans_next = {item_reg.shift_z, item_reg.shift_y, item_reg.shift_x};
                end
                default: begin
                    refused_next = 1'b0;
                end
            endcase
        end
        if (fin_go && pop_pend_reg) begin
            rot_next      = rd_reg.rot;
            trans_next    = rd_reg.trans;
            pop_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= SEQ_IDLE;
            rot_reg      <= '0;
            trans_reg    <= '0;
            level_reg    <= '0;
            refused_reg  <= 1'b0;
            pop_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rot_reg      <= rot_next;
            trans_reg    <= trans_next;
            level_reg    <= level_next;
            refused_reg  <= refused_next;
            pop_pend_reg <= pop_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_we) begin
            mem[wr_addr] <= wr_entry;
        end
        if (pop_re) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign vec = {item_reg.vec_z[COEF_W-1:0], item_reg.vec_y[COEF_W-1:0],
                  item_reg.vec_x[COEF_W-1:0]};

    always_comb begin
        lane_ctrl.capture   = exec_en;
        lane_ctrl.add_trans = (item_reg.cmd == CMD_ROT_TRANS);
        res_ctrl.load       = fin_go;
        res_ctrl.is_xform   = (item_reg.cmd == CMD_ROTATE) || (item_reg.cmd == CMD_ROT_TRANS);
        res_ctrl.refused    = refused_reg;
        res_ctrl.level      = LEVEL_W'(level_reg);
    end

    for (genvar r = 0; r < 3; r++) begin : g_lane
        msvt_lane u_lane (
            .aclk  (aclk),
            .ctrl  (lane_ctrl),
            .row   (rot_reg[r]),
            .vec   (vec),
            .trans (trans_reg[r]),
            .res   (lane_res[r])
        );
    end

    msvt_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (res_ctrl),
        .lane_res (lane_res),
        .free     (res_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    `MSVT_ASSERT_HOLDS(a_level_bound, level_reg <= LVL_W'(STACK_DEPTH))
    `MSVT_ASSERT_NEXT(a_push_level, push_we, level_reg == $past(level_reg) + 1'b1)
    `MSVT_ASSERT_NEXT(a_pop_level, pop_re, level_reg == $past(level_reg) - 1'b1)
    `MSVT_ASSERT_NEXT(a_refused_hold, exec_en && refused_next, level_reg == $past(level_reg))

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for matrix_stack_vector_transform: rotation, translation,
// matrix stack and row loads under random stalls on both channels.
// Depends on msvt_pkg and the block's RTL only.
module tb;
    import msvt_pkg::*;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 60;
    localparam int QUIET_LIMIT  = 1000;
    localparam int PRINT_CAP    = 40;

    class matrix_state_mirror;
        logic signed [15:0] rot [3][3];
        logic [31:0] trans [3];
        logic signed [15:0] saved_rot [STACK_DEPTH_DEF][3][3];
        logic [31:0] saved_trans [STACK_DEPTH_DEF][3];
        int unsigned level;
        out_item_t pending_outputs [$];
        int errors;

        function new();
            foreach (rot[r, c]) rot[r][c] = '0;
            foreach (trans[r]) trans[r] = '0;
            level = 0;
            errors = 0;
        endfunction

        function void take_command(in_item_t it);
            out_item_t res;
            logic signed [15:0] vv [3];
            logic signed [31:0] acc;
            logic signed [31:0] prod;
            logic [31:0] outv [3];
            res = '0;
            vv[0] = it.vec_x[15:0];
            vv[1] = it.vec_y[15:0];
            vv[2] = it.vec_z[15:0];
            foreach (outv[r]) outv[r] = '0;
            case (it.cmd)
                CMD_ROTATE, CMD_ROT_TRANS: begin
                    for (int r = 0; r < 3; r++) begin
                        acc = '0;
                        for (int c = 0; c < 3; c++) begin
                            prod = rot[r][c] * vv[c];
                            acc = acc + prod;
                        end
                        acc = acc >>> FRAC_BITS;
                        outv[r] = acc;
                        if (it.cmd == CMD_ROT_TRANS) outv[r] = outv[r] + trans[r];
                    end
                end
                CMD_PUSH: begin
                    if (level >= STACK_DEPTH_DEF) begin
                        res.refused = 1'b1;
                    end else begin
                        saved_rot[level] = rot;
                        saved_trans[level] = trans;
                        level++;
                    end
                end
                CMD_POP: begin
                    if (level == 0) begin
                        res.refused = 1'b1;
                    end else begin
                        level--;
                        rot = saved_rot[level];
                        trans = saved_trans[level];
                    end
                end
                CMD_LOAD_ROW: begin
                    if (it.row_sel < ROW_COUNT) begin
                        rot[it.row_sel][0] = it.coef_a;
                        rot[it.row_sel][1] = it.coef_b;
                        rot[it.row_sel][2] = it.coef_c;
                    end
                end
                CMD_LOAD_TRANS: begin
                    trans[0] = it.shift_x;
                    trans[1] = it.shift_y;
                    trans[2] = it.shift_z;
                end
                default: ;
            endcase
            res.out_x = outv[0];
            res.out_y = outv[1];
            res.out_z = outv[2];
            res.level = level[LEVEL_W-1:0];
            pending_outputs.push_back(res);
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] want_v);
            errors++;
            if (errors <= PRINT_CAP)
                $display("tb: mismatch in %s: got %h, expected %h", what, got_v, want_v);
        endtask

        task compare_result(out_item_t got);
            out_item_t want;
            if (pending_outputs.size() == 0) begin
                report("unexpected item", got.out_x, '0);
            end else begin
                want = pending_outputs.pop_front();
                if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
                if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
                if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
                if (got.refused !== want.refused)
                    report("refused", 32'(got.refused), 32'(want.refused));
                if (got.level !== want.level)
                    report("level", 32'(got.level), 32'(want.level));
            end
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    matrix_state_mirror mirror;
    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;
    bit hold_rx = 1'b0;
    int sent = 0;

    matrix_stack_vector_transform #(
        .STACK_DEPTH(STACK_DEPTH_DEF)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    function automatic logic signed [31:0] rand_vec();
        logic [15:0] low;
        low = 16'($urandom);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh0000_7FFF : 32'shFFFF_8000;
            default: return {{16{low[15]}}, low};
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coef();
        if ($urandom_range(0, 3) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 8192)) - 4096);
    endfunction

    function automatic in_item_t rand_item(logic [2:0] c);
        in_item_t it;
        it.cmd     = c;
        it.vec_x   = rand_vec();
        it.vec_y   = rand_vec();
        it.vec_z   = rand_vec();
        it.row_sel = 2'($urandom_range(0, 3));
        it.coef_a  = 16'($urandom);
        it.coef_b  = 16'($urandom);
        it.coef_c  = 16'($urandom);
        it.shift_x = $urandom;
        it.shift_y = $urandom;
        it.shift_z = $urandom;
        return it;
    endfunction

    task automatic offer(input in_item_t it);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        mirror.take_command(it);
        sent++;
    endtask

    task automatic load_row(input logic [1:0] sel, input logic signed [15:0] a,
                            input logic signed [15:0] b, input logic signed [15:0] c);
        in_item_t it;
        it = rand_item(CMD_LOAD_ROW);
        it.row_sel = sel;
        it.coef_a = a;
        it.coef_b = b;
        it.coef_c = c;
        offer(it);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (mirror.pending_outputs.size() != 0) @(posedge aclk);
    endtask

    initial begin : rx_side
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_rx) begin
                stall = HOLD_CYCLES;
                hold_rx = 1'b0;
            end else begin
                stall = rx_fast ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            mirror.compare_result(m_item);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        in_item_t it;
        int scene;
        int start_count;
        mirror = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        offer(rand_item(CMD_POP));
        it = rand_item(CMD_ROTATE);
        it.vec_x = 32'h7FFF_7FFF;
        offer(it);
        load_row(2'd0, 16'sd4096, 16'sd0, 16'sd0);
        load_row(2'd1, 16'sd0, 16'sd4096, 16'sd0);
        load_row(2'd2, 16'sd0, 16'sd0, 16'sd4096);
        load_row(2'd3, 16'($urandom), 16'($urandom), 16'($urandom));
        it = rand_item(CMD_ROTATE);
        it.vec_x = 32'h1234_7FFF;
        it.vec_y = 32'hFFFF_8000;
        it.vec_z = 32'hABCD_0001;
        offer(it);
        it = rand_item(CMD_LOAD_TRANS);
        it.shift_x = 32'h7FFF_FFFF;
        it.shift_y = 32'h8000_0000;
        it.shift_z = 32'hFFFF_FFFF;
        offer(it);
        it = rand_item(CMD_ROT_TRANS);
        it.vec_x = 32'h0000_7FFF;
        it.vec_y = 32'h0000_8000;
        it.vec_z = 32'hFFFF_0001;
        offer(it);
        load_row(2'd0, 16'sh8000, 16'sh8000, 16'sh8000);
        load_row(2'd1, 16'sd32767, 16'sd32767, 16'sd32767);
        load_row(2'd2, 16'sh8000, 16'sd32767, -16'sd1);
        it = rand_item(CMD_ROTATE);
        it.vec_x = 32'h5A5A_8000;
        it.vec_y = 32'hFFFF_8000;
        it.vec_z = 32'h0000_8000;
        offer(it);
        it = rand_item(CMD_ROT_TRANS);
        it.vec_x = 32'h0000_7FFF;
        it.vec_y = 32'h0000_7FFF;
        it.vec_z = 32'hFFFF_7FFF;
        offer(it);
        offer(rand_item(CMD_PUSH));
        it = rand_item(CMD_LOAD_TRANS);
        it.shift_x = '0;
        it.shift_y = '0;
        it.shift_z = '0;
        offer(it);
        offer(rand_item(CMD_PUSH));
        load_row(2'd0, rand_coef(), rand_coef(), rand_coef());
        offer(rand_item(CMD_POP));
        offer(rand_item(CMD_POP));
        offer(rand_item(CMD_ROT_TRANS));
        offer(rand_item(CMD_UNUSED_LO));
        offer(rand_item(CMD_UNUSED_HI));

        start_count = sent;
        scene = 0;
        while (sent - start_count < RANDOM_ITEMS) begin
            scene++;
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if (scene % 16 == 8) drain_outputs();
            if (scene == 10) begin
                hold_rx = 1'b1;
                tx_fast = 1'b1;
                repeat (12) offer(rand_item(CMD_ROTATE));
            end
            case ($urandom_range(0, 9))
                6: repeat ($urandom_range(STACK_DEPTH_DEF + 1, STACK_DEPTH_DEF + 3))
                    offer(rand_item(CMD_PUSH));
                7: repeat ($urandom_range(STACK_DEPTH_DEF + 1, STACK_DEPTH_DEF + 3)) begin
                    offer(rand_item(CMD_POP));
                    if ($urandom_range(0, 3) == 0) offer(rand_item(CMD_ROT_TRANS));
                end
                8: repeat ($urandom_range(4, 10)) offer(rand_item(3'($urandom_range(0, 7))));
                9: repeat ($urandom_range(2, 6))
                    offer(rand_item($urandom_range(0, 1) ? CMD_ROT_TRANS : CMD_ROTATE));
                default: begin
                    if ($urandom_range(0, 3) != 0) offer(rand_item(CMD_PUSH));
                    repeat ($urandom_range(1, 3))
                        load_row(2'($urandom_range(0, 2)), rand_coef(), rand_coef(),
                                 rand_coef());
                    if ($urandom_range(0, 1) == 1) offer(rand_item(CMD_LOAD_TRANS));
                    repeat ($urandom_range(2, 6))
                        offer(rand_item($urandom_range(0, 1) ? CMD_ROT_TRANS : CMD_ROTATE));
                    if ($urandom_range(0, 3) != 0) offer(rand_item(CMD_POP));
                end
            endcase
        end

        drain_outputs();
        repeat (8) @(posedge aclk);
        if (mirror.errors == 0 && mirror.pending_outputs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
